### sv/sbsc_pkg.sv
// Shared types, codes and constant tables for the steering and brake servo controller.
// No dependencies; every module of the block imports this package.
package sbsc_pkg;

	typedef enum logic [1:0] {
		ACT_DIST  = 2'd0,
		ACT_STEER = 2'd1,
		ACT_BRAKE = 2'd2,
		ACT_ENC   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		REG_MAX_TURN      = 3'd0,
		REG_SPEED_FLOOR   = 3'd1,
		REG_SPEED_CEIL    = 3'd2,
		REG_STEP_LIMIT    = 3'd3,
		REG_ENGAGE_SPEED  = 3'd4,
		REG_RELEASE_SPEED = 3'd5,
		REG_ENGAGED_ANGLE = 3'd6,
		REG_RELEASE_ANGLE = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		action_t    action;
		logic [9:0] left_gap;
		logic [9:0] right_gap;
		logic       brake_wanted;
	} item_t;

	typedef struct packed {
		logic        steer_level;
		logic [15:0] steer_reload;
		logic        brake_level;
		logic [15:0] brake_reload;
		logic [6:0]  target_angle;
		logic [6:0]  steer_angle;
		logic [4:0]  speed_value;
		logic [6:0]  brake_angle;
	} result_t;

	typedef struct packed {
		logic capture;
		logic div_init;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
	} status_t;

	localparam int DIV_STEPS  = 16;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int CENTER_DEG = 90;
	localparam int SPEED_SPAN = 32;

	localparam logic [5:0] RST_MAX_TURN      = 6'd30;
	localparam logic [4:0] RST_SPEED_FLOOR   = 5'd6;
	localparam logic [4:0] RST_SPEED_CEIL    = 5'd25;
	localparam logic [9:0] RST_STEP_LIMIT    = 10'd50;
	localparam logic [4:0] RST_ENGAGE_SPEED  = 5'd15;
	localparam logic [4:0] RST_RELEASE_SPEED = 5'd8;
	localparam logic [6:0] RST_ENGAGED_ANGLE = 7'd93;
	localparam logic [6:0] RST_RELEASE_ANGLE = 7'd70;
	localparam logic [6:0] RST_BRAKE_DEG     = 7'd70;
	localparam logic [4:0] RST_SPEED         = 5'd6;

	typedef logic [15:0] rl_tbl_t [0:127];

	// high phase: 65075 - ceil(10.23*a); low phase: 47566 + floor(10.23*a)
	function automatic rl_tbl_t build_high();
		rl_tbl_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = 16'(65075 - (1023 * i + 99) / 100);
		end
		return t;
	endfunction

	function automatic rl_tbl_t build_low();
		rl_tbl_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = 16'(47566 + (1023 * i) / 100);
		end
		return t;
	endfunction

	localparam rl_tbl_t HIGH_RL = build_high();
	localparam rl_tbl_t LOW_RL  = build_low();

endpackage

### sv/sbsc_ctrl.sv
// Sequencer of the servo controller: accepts a beat, runs the shared divider, commits.
// Depends on sbsc_pkg.
module sbsc_ctrl import sbsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic result_valid_q;
	logic out_free;
	logic cnt_last;

	assign out_free = !result_valid_q || !result_stall;
	assign cnt_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign result_valid = result_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_nx = ST_PREP;
			end
			ST_PREP: begin
				state_nx = status.need_div ? ST_DIV : ST_COMMIT;
			end
			ST_DIV: begin
				if (cnt_last) state_nx = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.capture = item_valid;
			end
			ST_PREP: cmd.div_init = status.need_div;
			ST_DIV: cmd.div_step = 1'b1;
			ST_COMMIT: cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
			if (cmd.commit) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(result_valid_q && result_stall))
		else $error("result overwritten while stalled");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_last) |=> state_q == ST_COMMIT)
		else $error("divider run length wrong");

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> state_q == ST_PREP)
		else $error("accepted beat not taken up");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result_valid_q)
		else $error("committed result not shown");

endmodule

### sv/sbsc_dp.sv
// Datapath of the servo controller: registers, shared restoring divider, update logic.
// Depends on sbsc_pkg; driven by sbsc_ctrl commands.
module sbsc_dp import sbsc_pkg::*; #(
	parameter int ANGLE_LOW  = 60,
	parameter int ANGLE_HIGH = 120,
	parameter int PERIOD_LEN = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  cmd_t       cmd,
	output status_t    status,
	input  logic       cfg_we,
	input  cfg_idx_t   cfg_index,
	input  logic [9:0] cfg_data,
	output result_t    result
);

	logic [5:0] max_turn_q;
	logic [4:0] floor_q, ceil_q, engage_q, release_q;
	logic [9:0] step_lim_q;
	logic [6:0] eng_ang_q, rel_ang_q;

	logic       steer_phase_q, brake_phase_q;
	logic [6:0] target_q, cur_q, brake_q;
	logic [4:0] speed_q, ticks_q;
	logic [15:0] pulse_q, last_q;

	item_t item_q;
	result_t result_q;
	logic [15:0] quo_q;
	logic [9:0]  rem_q, dvs_q;

	function automatic logic [6:0] clamp_ang(logic signed [9:0] a);
		if (a < ANGLE_LOW) return 7'(ANGLE_LOW);
		if (a > ANGLE_HIGH) return 7'(ANGLE_HIGH);
		return a[6:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_turn_q <= RST_MAX_TURN;
			floor_q <= RST_SPEED_FLOOR;
			ceil_q <= RST_SPEED_CEIL;
			step_lim_q <= RST_STEP_LIMIT;
			engage_q <= RST_ENGAGE_SPEED;
			release_q <= RST_RELEASE_SPEED;
			eng_ang_q <= RST_ENGAGED_ANGLE;
			rel_ang_q <= RST_RELEASE_ANGLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_TURN:      max_turn_q <= cfg_data[5:0];
				REG_SPEED_FLOOR:   floor_q <= cfg_data[4:0];
				REG_SPEED_CEIL:    ceil_q <= cfg_data[4:0];
				REG_STEP_LIMIT:    step_lim_q <= cfg_data;
				REG_ENGAGE_SPEED:  engage_q <= cfg_data[4:0];
				REG_RELEASE_SPEED: release_q <= cfg_data[4:0];
				REG_ENGAGED_ANGLE: eng_ang_q <= cfg_data[6:0];
				REG_RELEASE_ANGLE: rel_ang_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// operand preparation
	logic        left_wider;
	logic [9:0]  gap_diff, gap_small;
	logic [15:0] prod;
	logic [6:0]  ang_diff;
	logic [5:0]  inv_base;
	logic [7:0]  inv3;

	always_comb begin
		left_wider = item_q.left_gap > item_q.right_gap;
		gap_diff = left_wider ? item_q.left_gap - item_q.right_gap
			: item_q.right_gap - item_q.left_gap;
		gap_small = left_wider ? item_q.right_gap : item_q.left_gap;
		prod = 16'(max_turn_q) * 16'(gap_diff);
		ang_diff = (target_q > cur_q) ? target_q - cur_q : cur_q - target_q;
		inv_base = 6'(SPEED_SPAN) - {1'b0, speed_q};
		inv3 = 8'(inv_base) * 8'd3;
	end

	assign status.need_div = (item_q.action == ACT_DIST && gap_small != '0)
		|| (item_q.action == ACT_STEER && steer_phase_q);

	// restoring divider, one quotient bit a cycle
	logic [10:0] rem_sh;
	logic        fits;
	assign rem_sh = {rem_q, quo_q[15]};
	assign fits = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= item;
		if (cmd.div_init) begin
			rem_q <= '0;
			if (item_q.action == ACT_DIST) begin
				quo_q <= prod;
				dvs_q <= gap_small;
			end else begin
				quo_q <= 16'(ang_diff);
				dvs_q <= 10'(inv3[7:1]);
			end
		end else if (cmd.div_step) begin
			rem_q <= fits ? 10'(rem_sh - {1'b0, dvs_q}) : rem_sh[9:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	// update for the committed beat
	logic        steer_ph_nx, brake_ph_nx;
	logic [15:0] steer_rl, brake_rl;
	logic [6:0]  target_nx, cur_nx, brake_nx;
	logic [4:0]  speed_nx, ticks_nx, tick_inc, spd_c;
	logic [15:0] pulse_nx, last_nx, cnt;
	logic [16:0] lim;
	logic [5:0]  turn;
	logic [9:0]  tsum, step, csum;

	always_comb begin
		steer_ph_nx = steer_phase_q;
		brake_ph_nx = brake_phase_q;
		steer_rl = '0;
		brake_rl = '0;
		target_nx = target_q;
		cur_nx = cur_q;
		brake_nx = brake_q;
		speed_nx = speed_q;
		ticks_nx = ticks_q;
		pulse_nx = pulse_q;
		last_nx = last_q;
		turn = (gap_small == '0 || quo_q > 16'(max_turn_q)) ? max_turn_q : quo_q[5:0];
		tsum = left_wider ? 10'(CENTER_DEG) - 10'(turn) : 10'(CENTER_DEG) + 10'(turn);
		step = 10'(quo_q[7:0]) + 10'd2;
		if (target_q > cur_q) csum = 10'(cur_q) + step;
		else if (target_q < cur_q) csum = 10'(cur_q) - step;
		else csum = 10'(cur_q);
		tick_inc = ticks_q + 5'd1;
		lim = 17'(last_q) + 17'(step_lim_q);
		cnt = (17'(pulse_q) > lim) ? lim[15:0] : pulse_q;
		spd_c = (cnt > 16'(ceil_q)) ? ceil_q : cnt[4:0];
		unique case (item_q.action)
			ACT_DIST: target_nx = clamp_ang($signed(tsum));
			ACT_STEER: begin
				steer_ph_nx = !steer_phase_q;
				if (!steer_phase_q) begin
					steer_rl = HIGH_RL[cur_q];
				end else begin
					steer_rl = LOW_RL[cur_q];
					cur_nx = clamp_ang($signed(csum));
				end
			end
			ACT_BRAKE: begin
				brake_ph_nx = !brake_phase_q;
				if (!brake_phase_q) begin
					brake_rl = HIGH_RL[brake_q];
				end else begin
					brake_rl = LOW_RL[brake_q];
					ticks_nx = tick_inc;
					if (tick_inc >= 5'(PERIOD_LEN)) begin
						// measure speed, then apply brake hysteresis
						ticks_nx = '0;
						last_nx = cnt;
						pulse_nx = '0;
						speed_nx = (spd_c < floor_q) ? floor_q : spd_c;
						if (!item_q.brake_wanted) begin
							brake_nx = clamp_ang(10'(rel_ang_q));
						end else if (speed_nx >= engage_q) begin
							brake_nx = clamp_ang(10'(eng_ang_q));
						end else if (speed_nx <= release_q) begin
							brake_nx = clamp_ang(10'(rel_ang_q));
						end
					end
				end
			end
			ACT_ENC: begin
				if (pulse_q != 16'hFFFF) pulse_nx = pulse_q + 16'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_phase_q <= 1'b0;
			brake_phase_q <= 1'b0;
			target_q <= 7'(CENTER_DEG);
			cur_q <= 7'(CENTER_DEG);
			brake_q <= RST_BRAKE_DEG;
			speed_q <= RST_SPEED;
			ticks_q <= '0;
			pulse_q <= '0;
			last_q <= '0;
		end else if (cmd.commit) begin
			steer_phase_q <= steer_ph_nx;
			brake_phase_q <= brake_ph_nx;
			target_q <= target_nx;
			cur_q <= cur_nx;
			brake_q <= brake_nx;
			speed_q <= speed_nx;
			ticks_q <= ticks_nx;
			pulse_q <= pulse_nx;
			last_q <= last_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.steer_level <= steer_ph_nx;
			result_q.steer_reload <= steer_rl;
			result_q.brake_level <= brake_ph_nx;
			result_q.brake_reload <= brake_rl;
			result_q.target_angle <= target_nx;
			result_q.steer_angle <= cur_nx;
			result_q.speed_value <= speed_nx;
			result_q.brake_angle <= brake_nx;
		end
	end

	assign result = result_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < dvs_q)
		else $error("divider remainder out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> dvs_q != '0)
		else $error("divider started on zero divisor");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.commit) && item_q.action == ACT_STEER |->
		(32'(cur_q) >= ANGLE_LOW || !steer_phase_q == 1'b0))
		else $error("steering angle below range after slew");

endmodule

### sv/steering_brake_servo_controller.sv
// Steering and brake servo controller, event driven: one beat in, one result beat out.
// Channels: item (item_valid/item_stall, payload item) carries one event: a distance
// update, a steering or brake timer expiry, or an encoder pulse. result
// (result_valid/result_stall, payload result) returns pulse levels, timer reloads for
// the phase just begun, angles and speed. cfg (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes the eight settings; cfg_ready is always high, write while idle.
// Divider use: a distance update with a nonzero smaller gap and the end of a steering
// high phase go through the shared 16-step restoring divider; other events skip it.
// One event is in work at a time and the block returns to idle after each commit, so
// the next event is accepted only once the last one has committed.
// A finished result sits in an output register; the next beat is accepted while it
// waits. A stalled result holds until taken; only then can a later result commit.
// Reset: angles to centre, brake to its released angle, speed to 6, counts cleared,
// settings to their defaults; no result pending.
module steering_brake_servo_controller import sbsc_pkg::*; #(
	parameter int ANGLE_LOW  = 60,
	parameter int ANGLE_HIGH = 120,
	parameter int PERIOD_LEN = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_idx_t   cfg_index,
	input  logic [9:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	sbsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	sbsc_dp #(
		.ANGLE_LOW  (ANGLE_LOW),
		.ANGLE_HIGH (ANGLE_HIGH),
		.PERIOD_LEN (PERIOD_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule
